FILE: hdl/ssr_pkg.sv
// Shared types and constants for the streaming substring replacer.
package ssr_pkg;

    localparam int MAX_PATTERN_DEF = 8;
    localparam int REPL_MAX        = 8;
    localparam int JOB_BYTES       = 8;
    localparam int JOB_CNT_W       = $clog2(JOB_BYTES + 1);
    localparam int JOB_IDX_W       = $clog2(JOB_BYTES);
    localparam int QUEUE_DEPTH     = 2;  // power of two
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_ADDR_W      = 5;
    localparam int LEN_W           = 4;

    typedef enum logic [1:0] {
        REG_PATTERN_BYTES,
        REG_PATTERN_LENGTH,
        REG_REPLACEMENT_BYTES,
        REG_REPLACEMENT_LENGTH
    } cfg_reg_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] pattern;
        logic [LEN_W-1:0]      pattern_len;
        logic [CFG_DATA_W-1:0] replacement;
        logic [LEN_W-1:0]      replacement_len;
    } cfg_t;

    // One burst of output beats produced by a single input beat.
    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] data;
        logic [JOB_CNT_W-1:0]      count;
        logic                      last;
    } job_t;

endpackage

FILE: hdl/ssr_front.sv
// Front end: pending-byte window, pattern compare and burst classification.
module ssr_front #(
    parameter int MaxPattern = ssr_pkg::MAX_PATTERN_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic [7:0]                      in_byte,
    input  logic                            in_last,
    input  ssr_pkg::cfg_t                   cfg,
    input  logic                            cfg_clear,
    output logic                            push,
    output ssr_pkg::job_t                   job,
    output logic [$clog2(MaxPattern+1)-1:0] fill
);
    import ssr_pkg::*;

    localparam int FILL_W = $clog2(MaxPattern + 1);

    logic [7:0]        win_reg [MaxPattern];
    logic [7:0]        win_next [MaxPattern];
    logic [7:0]        w [MaxPattern];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [FILL_W-1:0] fill_eff;
    logic [LEN_W-1:0]  plen;
    logic [LEN_W-1:0]  rlen;
    logic [LEN_W-1:0]  fill_new;
    logic              disabled;
    logic              full;
    logic              match;

    assign plen = (cfg.pattern_len > LEN_W'(MaxPattern)) ? LEN_W'(MaxPattern) : cfg.pattern_len;
    assign rlen = (cfg.replacement_len > LEN_W'(REPL_MAX)) ? LEN_W'(REPL_MAX)
                                                           : cfg.replacement_len;
    assign disabled = (plen == '0) || (rlen == '0);
    assign fill_eff = (LEN_W'(fill_reg) >= plen) ? '0 : fill_reg;
    assign fill_new = LEN_W'(fill_eff) + LEN_W'(1);
    assign full     = (fill_new == plen);
    assign fill     = fill_reg;

    always_comb
    begin
        for (int i = 0; i < MaxPattern; i++)
        begin
            w[i] = (FILL_W'(i) == fill_eff) ? in_byte : win_reg[i];
        end
        match = 1'b1;
        for (int i = 0; i < MaxPattern; i++)
        begin
            if ((LEN_W'(i) < plen) && (w[i] != cfg.pattern[8*i +: 8]))
            begin
                match = 1'b0;
            end
        end
    end

    always_comb
    begin
        win_next  = w;
        fill_next = fill_reg;
        job.data  = '0;
        job.count = '0;
        job.last  = in_last;
        for (int j = 0; j < MaxPattern; j++)
        begin
            job.data[j] = w[j];
        end
        if (disabled)
        begin
            job.data[0] = in_byte;
            job.count   = JOB_CNT_W'(1);
            fill_next   = '0;
        end
        else if (full && match)
        begin
            for (int j = 0; j < JOB_BYTES; j++)
            begin
                job.data[j] = cfg.replacement[8*j +: 8];
            end
            job.count = JOB_CNT_W'(rlen);
            fill_next = '0;
        end
        else if (full)
        begin
            for (int i = 0; i < MaxPattern - 1; i++)
            begin
                win_next[i] = w[i+1];
            end
            job.count = in_last ? JOB_CNT_W'(plen) : JOB_CNT_W'(1);
            fill_next = in_last ? '0 : FILL_W'(plen - LEN_W'(1));
        end
        else
        begin
            job.count = in_last ? JOB_CNT_W'(fill_new) : '0;
            fill_next = in_last ? '0 : FILL_W'(fill_new);
        end
    end

    assign push = accept && (job.count != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (cfg_clear)
        begin
            fill_reg <= '0;
        end
        else if (accept)
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            win_reg <= win_next;
        end
    end

endmodule

FILE: hdl/ssr_queue.sv
// Short burst queue between front and back ends.
module ssr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ssr_pkg::job_t wr_job,
    input  logic          pop,
    output ssr_pkg::job_t head,
    output logic          full,
    output logic          empty
);
    import ssr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign full  = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

FILE: hdl/ssr_back.sv
// Back end: serializes queued bursts into registered output beats.
module ssr_back (
    input  logic          clk,
    input  logic          rst_n,
    input  ssr_pkg::job_t head,
    input  logic          empty,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [7:0]    out_byte,
    output logic          run_last,
    output logic          string_end
);
    import ssr_pkg::*;

    logic [JOB_IDX_W-1:0] idx_reg;
    logic                 valid_reg;
    logic [7:0]           byte_reg;
    logic                 run_last_reg;
    logic                 end_reg;
    logic                 load;
    logic                 final_beat;

    assign load       = !empty && (!valid_reg || !out_stall);
    assign final_beat = (JOB_CNT_W'(idx_reg) + JOB_CNT_W'(1)) == head.count;
    assign pop        = load && final_beat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= final_beat ? '0 : idx_reg + JOB_IDX_W'(1);
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg     <= head.data[idx_reg];
            run_last_reg <= final_beat;
            end_reg      <= final_beat && head.last;
        end
    end

    assign out_valid  = valid_reg;
    assign out_byte   = byte_reg;
    assign run_last   = run_last_reg;
    assign string_end = end_reg;

endmodule

FILE: hdl/stream_substring_replace.sv
// Top level of the streaming substring replacer with its register port.
//
// Input channel: in_valid/in_stall carry one string byte per beat, with
// in_last on the final byte. Output channel: out_valid/out_stall carry the
// rewritten bytes; run_last marks the last beat caused by one input beat,
// string_end the final beat of the rewritten string.
// Registers (64-bit APB, 8-byte stride): pattern bytes, pattern length,
// replacement bytes, replacement length. A write drops pending window bytes.
// Either length zero makes bytes pass through unchanged.
// Throughput: one input beat per cycle unless in_stall, one output beat
// per cycle unless out_stall; an input beat that completes a match yields
// a burst of replacement_length beats (at most 8), and the output port
// emits one beat a cycle, so longer bursts hold in_stall high once the
// two-entry queue is full. Each burst is queued, then loaded into out_byte.
// Reset clears the window fill count, queue and output valid; registers
// reset to zero. A stalled output beat holds while the queue keeps taking
// input until it fills.
module stream_substring_replace #(
    parameter int MaxPattern = ssr_pkg::MAX_PATTERN_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     in_byte,
    input  logic                           in_last,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [7:0]                     out_byte,
    output logic                           run_last,
    output logic                           string_end,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ssr_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [ssr_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [ssr_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import ssr_pkg::*;

    localparam int FILL_W = $clog2(MaxPattern + 1);

    cfg_t              cfg_reg;
    cfg_reg_t          reg_sel;
    logic              cfg_wr;
    logic              accept;
    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_empty;
    job_t              front_job;
    job_t              q_head;
    logic [FILL_W-1:0] fill;
    logic [LEN_W-1:0]  plen_sat;

    assign pready  = 1'b1;
    assign reg_sel = cfg_reg_t'(paddr[4:3]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_PATTERN_BYTES:      cfg_reg.pattern         <= pwdata;
                REG_PATTERN_LENGTH:     cfg_reg.pattern_len     <= pwdata[LEN_W-1:0];
                REG_REPLACEMENT_BYTES:  cfg_reg.replacement     <= pwdata;
                REG_REPLACEMENT_LENGTH: cfg_reg.replacement_len <= pwdata[LEN_W-1:0];
                default:                cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_PATTERN_BYTES:      prdata = cfg_reg.pattern;
            REG_PATTERN_LENGTH:     prdata = CFG_DATA_W'(cfg_reg.pattern_len);
            REG_REPLACEMENT_BYTES:  prdata = cfg_reg.replacement;
            REG_REPLACEMENT_LENGTH: prdata = CFG_DATA_W'(cfg_reg.replacement_len);
            default:                prdata = '0;
        endcase
    end

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    ssr_front #(
        .MaxPattern(MaxPattern)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .cfg      (cfg_reg),
        .cfg_clear(cfg_wr),
        .push     (push),
        .job      (front_job),
        .fill     (fill)
    );

    ssr_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wr_job(front_job),
        .pop   (pop),
        .head  (q_head),
        .full  (q_full),
        .empty (q_empty)
    );

    ssr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .empty     (q_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .run_last  (run_last),
        .string_end(string_end)
    );

    assign plen_sat = (cfg_reg.pattern_len > LEN_W'(MaxPattern)) ? LEN_W'(MaxPattern)
                                                                  : cfg_reg.pattern_len;

    // string end only on the closing beat of a burst
    a_end_on_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!string_end || run_last))
        else $error("string_end without run_last");

    // pending bytes never reach a full pattern between beats
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (fill == '0) || (LEN_W'(fill) < plen_sat))
        else $error("window fill out of range");

    // register write drops the window
    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> (fill == '0))
        else $error("window not cleared by register write");

    // a string-final input always produces at least one beat
    a_last_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_last) |-> push)
        else $error("final input beat produced no output");

endmodule

FILE: bench/tb_stream_substring_replace.sv
// Self-checking testbench for stream_substring_replace: directed table, then random strings.
module tb_stream_substring_replace;
    import ssr_pkg::*;

    localparam int RANDOM_BEATS  = 200;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 6;
    localparam int DRAIN_CYCLES  = 20;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       string_end;
    } out_beat_t;

    typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        cfg_reg_t    reg_sel;
        logic [63:0] value;
        logic [7:0]  data;
        logic        lst;
        bit          typed;
        out_beat_t   want;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [7:0]            in_byte;
    logic                  in_last;
    logic                  out_valid;
    logic                  out_stall;
    logic [7:0]            out_byte;
    logic                  run_last;
    logic                  string_end;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // replacer state mirrored by the predictor
    logic [63:0] pat_bytes = '0;
    logic [3:0]  pat_len   = '0;
    logic [63:0] rep_bytes = '0;
    logic [3:0]  rep_len   = '0;
    logic [7:0]  win [8];
    int          win_fill  = 0;

    out_beat_t   expected_beats [$];
    stim_row_t   directed_rows [$];
    out_beat_t   got;
    out_beat_t   want_beat;

    bit          quiet     = 0;
    bit          small_abc = 0;
    logic [7:0]  alpha [2];

    int          errors        = 0;
    int          beats_sent    = 0;
    int          beats_checked = 0;
    int          cfg_writes    = 0;
    int          cycles        = 0;

    stream_substring_replace dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void predict_beat(input logic [7:0] b, input logic lst, input bit record);
        out_beat_t burst [8];
        int        n;
        int        plen;
        int        rlen;
        int        i;
        bit        hit;
        n = 0;
        plen = (pat_len > 8) ? 8 : int'(pat_len);
        rlen = (rep_len > 8) ? 8 : int'(rep_len);
        if (plen == 0 || rlen == 0)
        begin
            burst[n] = {b, 2'b00};
            n++;
            win_fill = 0;
        end
        else
        begin
            if (win_fill >= plen)
                win_fill = 0;
            win[win_fill] = b;
            win_fill++;
            if (win_fill >= plen)
            begin
                hit = 1;
                for (i = 0; i < plen; i++)
                    if (win[i] != pat_bytes[8*i +: 8])
                        hit = 0;
                if (hit)
                begin
                    for (i = 0; i < rlen; i++)
                    begin
                        burst[n] = {rep_bytes[8*i +: 8], 2'b00};
                        n++;
                    end
                    win_fill = 0;
                end
                else
                begin
                    burst[n] = {win[0], 2'b00};
                    n++;
                    for (i = 1; i < win_fill; i++)
                        win[i-1] = win[i];
                    win_fill--;
                end
            end
            if (lst)
            begin
                for (i = 0; i < win_fill; i++)
                begin
                    burst[n] = {win[i], 2'b00};
                    n++;
                end
                win_fill = 0;
            end
        end
        if (n > 0)
        begin
            burst[n-1].run_last   = 1'b1;
            burst[n-1].string_end = lst;
        end
        if (record)
            for (i = 0; i < n; i++)
                expected_beats.push_back(burst[i]);
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [3:0] pick_len();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 4'd0;
        if (r == 1)
            return 4'($urandom_range(9, 15));
        if (r < 5)
            return 4'd8;
        if (r < 8)
            return 4'd1;
        return 4'($urandom_range(2, 7));
    endfunction

    function automatic logic [7:0] noise_byte();
        if (small_abc)
            return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                               : alpha[$urandom_range(0, 1)];
        if ($urandom_range(0, 1) == 0)
            return pat_bytes[8*$urandom_range(0, 7) +: 8];
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void add_cfg(input cfg_reg_t r, input logic [63:0] v);
        stim_row_t row;
        row.kind    = ROW_CFG;
        row.reg_sel = r;
        row.value   = v;
        row.data    = '0;
        row.lst     = 1'b0;
        row.typed   = 0;
        row.want    = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_beat(input logic [7:0] d, input logic lst,
                                     input bit typed = 0, input out_beat_t want = '0);
        stim_row_t row;
        row.kind    = ROW_BEAT;
        row.reg_sel = REG_PATTERN_BYTES;
        row.value   = '0;
        row.data    = d;
        row.lst     = lst;
        row.typed   = typed;
        row.want    = want;
        directed_rows.push_back(row);
    endfunction

    function automatic logic [7:0] pv_byte(input logic [63:0] v, input int idx);
        return v[8*idx +: 8];
    endfunction

    task automatic send_beat(input logic [7:0] b, input logic lst,
                             input bit typed, input out_beat_t want);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_last  <= lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_beat(b, lst, !typed);
        if (typed)
            expected_beats.push_back(want);
        beats_sent++;
    endtask

    // register write only once the output side has drained
    task automatic cfg_write(input cfg_reg_t r, input logic [63:0] v);
        in_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(int'(r) * 8);
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (r)
            REG_PATTERN_BYTES:      pat_bytes = v;
            REG_PATTERN_LENGTH:     pat_len   = v[3:0];
            REG_REPLACEMENT_BYTES:  rep_bytes = v;
            REG_REPLACEMENT_LENGTH: rep_len   = v[3:0];
            default: ;
        endcase
        win_fill = 0;
        cfg_writes++;
    endtask

    // output stall: random stretches, none while quiet
    initial
    begin
        int s;
        out_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            s = pick_gap();
            if (s > 0)
            begin
                out_stall <= 1'b1;
                repeat (s) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got = {out_byte, run_last, string_end};
            if (expected_beats.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat byte=%02h run_last=%0b string_end=%0b",
                         $time, out_byte, run_last, string_end);
            end
            else
            begin
                want_beat = expected_beats.pop_front();
                beats_checked++;
                if (got.data !== want_beat.data || got.run_last !== want_beat.run_last ||
                    got.string_end !== want_beat.string_end)
                begin
                    errors++;
                    $display("%0t: mismatch exp %02h/%0b/%0b got %02h/%0b/%0b",
                             $time, want_beat.data, want_beat.run_last, want_beat.string_end,
                             got.data, got.run_last, got.string_end);
                end
            end
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles, %0d beats still expected",
                 cycles, expected_beats.size());
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        logic [7:0]  str [$];
        logic [63:0] pv;
        logic [3:0]  pl;
        logic [3:0]  rl;
        int          random_beats;
        int          plen_eff;
        int          target;
        int          seg;
        int          nstr;
        int          s;
        int          k;
        int          j;
        bit          broken;

        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_byte  <= '0;
        in_last  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        random_beats = 0;

        // after reset both lengths are zero: bytes pass straight through
        add_beat(8'h00, 1'b0, 1, {8'h00, 1'b1, 1'b0});
        add_beat(8'hFF, 1'b0, 1, {8'hFF, 1'b1, 1'b0});
        add_beat(8'h5A, 1'b1, 1, {8'h5A, 1'b1, 1'b1});
        add_cfg(REG_PATTERN_BYTES, 64'h0000_0000_0063_6261);
        add_cfg(REG_PATTERN_LENGTH, 64'd3);
        add_beat(8'h61, 1'b0, 1, {8'h61, 1'b1, 1'b0});
        add_cfg(REG_REPLACEMENT_BYTES, 64'h0000_0000_5A59_5857);
        add_cfg(REG_REPLACEMENT_LENGTH, 64'd4);
        add_beat(8'h78, 1'b0);
        add_beat(8'h61, 1'b0);
        add_beat(8'h62, 1'b0);
        add_beat(8'h63, 1'b0);
        add_beat(8'h61, 1'b0);
        add_beat(8'h62, 1'b0);
        // write with bytes pending in the window drops them
        add_cfg(REG_REPLACEMENT_LENGTH, 64'd2);
        add_beat(8'h63, 1'b0);
        add_beat(8'h71, 1'b1);
        // overlong lengths saturate at 8, zero bytes inside the pattern
        add_cfg(REG_PATTERN_BYTES, 64'hFF00_00FF_0080_01FF);
        add_cfg(REG_PATTERN_LENGTH, 64'd15);
        add_cfg(REG_REPLACEMENT_BYTES, 64'hFFEE_DDCC_BBAA_0099);
        add_cfg(REG_REPLACEMENT_LENGTH, 64'd12);
        for (j = 0; j < 8; j++)
            add_beat(pv_byte(64'hFF00_00FF_0080_01FF, j), j == 7);
        add_cfg(REG_PATTERN_BYTES, 64'd0);
        add_cfg(REG_PATTERN_LENGTH, 64'd1);
        add_cfg(REG_REPLACEMENT_BYTES, 64'h0000_0000_0000_00FF);
        add_cfg(REG_REPLACEMENT_LENGTH, 64'd1);
        add_beat(8'h00, 1'b0);
        add_beat(8'h7F, 1'b0);
        add_beat(8'h00, 1'b1);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
                cfg_write(directed_rows[i].reg_sel, directed_rows[i].value);
            else
                send_beat(directed_rows[i].data, directed_rows[i].lst,
                          directed_rows[i].typed, directed_rows[i].want);
        end

        while (random_beats < RANDOM_BEATS)
        begin
            quiet     = ($urandom_range(0, 3) == 0);
            small_abc = ($urandom_range(0, 2) == 0);
            alpha[0]  = 8'($urandom_range(0, 255));
            alpha[1]  = 8'($urandom_range(0, 255));
            pv = {$urandom, $urandom};
            if (small_abc)
                for (k = 0; k < 8; k++)
                    pv[8*k +: 8] = alpha[$urandom_range(0, 1)];
            pl = pick_len();
            rl = pick_len();
            cfg_write(REG_PATTERN_BYTES, pv);
            cfg_write(REG_PATTERN_LENGTH, {60'd0, pl});
            cfg_write(REG_REPLACEMENT_BYTES, {$urandom, $urandom});
            cfg_write(REG_REPLACEMENT_LENGTH, {60'd0, rl});
            plen_eff = (pl > 8) ? 8 : int'(pl);
            if (plen_eff == 0)
                plen_eff = 3;
            nstr = $urandom_range(2, 5);
            for (s = 0; s < nstr; s++)
            begin
                str.delete();
                target = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 30)
                                                     : $urandom_range(1, 12);
                while (str.size() < target)
                begin
                    seg = $urandom_range(0, 99);
                    if (seg < 45)
                        for (k = 0; k < plen_eff; k++)
                            str.push_back(pat_bytes[8*k +: 8]);
                    else if (seg < 65)
                        for (k = 0; k < int'($urandom_range(0, plen_eff - 1)); k++)
                            str.push_back(pat_bytes[8*k +: 8]);
                    else
                        str.push_back(noise_byte());
                end
                // now and then the phase ends inside a string
                broken = (s == nstr - 1) && ($urandom_range(0, 5) == 0);
                for (k = 0; k < str.size(); k++)
                    send_beat(str[k], (k == str.size() - 1) && !broken, 0, '0);
                random_beats += str.size();
            end
        end

        in_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes across %0d register writes, checked %0d output beats.",
                 beats_sent, cfg_writes, beats_checked);
        $display("Covered pass-through, saturated lengths, long bursts and dropped windows.");
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: files.f
hdl/ssr_pkg.sv
hdl/ssr_front.sv
hdl/ssr_queue.sv
hdl/ssr_back.sv
hdl/stream_substring_replace.sv
bench/tb_stream_substring_replace.sv
